@@ sv/vertex_normal_generator_defines.svh @@
// ----------------------------------------------------------------------------
// Vertex normal generator assertion macros
// Shared property forms used by the assertion sections of the RTL.
// ----------------------------------------------------------------------------
`ifndef VERTEX_NORMAL_GENERATOR_DEFINES_SVH
`define VERTEX_NORMAL_GENERATOR_DEFINES_SVH

// same-cycle implication on clk, off during rst
`define VNG_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("vng check failed");

// next-cycle implication on clk, off during rst
`define VNG_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("vng check failed");

`endif

@@ sv/vng_pkg.sv @@
// ----------------------------------------------------------------------------
// Vertex normal generator package
// Widths, command codes and word types shared by the generator modules.
// ----------------------------------------------------------------------------
package vng_pkg;

  localparam int VERTEX_DEPTH   = 1024;
  localparam int INDEX_W        = $clog2(VERTEX_DEPTH);
  localparam int POSITION_WIDTH = 16;
  localparam int SUM_W          = 48;
  localparam int NORM_W         = 16;
  localparam int FRAC_W         = 14;

  localparam logic [1:0] KIND_LOAD = 2'd0;
  localparam logic [1:0] KIND_TRI  = 2'd1;
  localparam logic [1:0] KIND_READ = 2'd2;

  typedef struct packed {
    logic [1:0]                       kind;
    logic [INDEX_W-1:0]               index_a;
    logic [INDEX_W-1:0]               index_b;
    logic [INDEX_W-1:0]               index_c;
    logic signed [POSITION_WIDTH-1:0] pos_x;
    logic signed [POSITION_WIDTH-1:0] pos_y;
    logic signed [POSITION_WIDTH-1:0] pos_z;
  } cmd_t;

  typedef struct packed {
    logic [INDEX_W-1:0]       vertex_index;
    logic signed [NORM_W-1:0] norm_x;
    logic signed [NORM_W-1:0] norm_y;
    logic signed [NORM_W-1:0] norm_z;
    logic                     degenerate;
  } result_t;

  typedef struct packed {
    logic signed [POSITION_WIDTH-1:0] x;
    logic signed [POSITION_WIDTH-1:0] y;
    logic signed [POSITION_WIDTH-1:0] z;
  } pos3_t;

  typedef struct packed {
    logic signed [SUM_W-1:0] x;
    logic signed [SUM_W-1:0] y;
    logic signed [SUM_W-1:0] z;
  } sum3_t;

  typedef struct packed {
    logic signed [NORM_W-1:0] x;
    logic signed [NORM_W-1:0] y;
    logic signed [NORM_W-1:0] z;
    logic                     degenerate;
  } norm_res_t;

endpackage

@@ sv/vertex_normal_generator.sv @@
// ----------------------------------------------------------------------------
// Vertex normal generator
// Load: busy stays low. Triangle: three position reads then three
//   read-modify-write passes over the sum RAM, one port each.
// Read: 0 to 29 shift steps, 31 root steps and three rounded divides, all
//   skipped for a zero sum; the result is strobed as busy falls.
// One word at a time; results are strobed for one cycle and cannot be held.
// Reset clears control only; RAM contents are undefined until loaded.
// ----------------------------------------------------------------------------
`include "vertex_normal_generator_defines.svh"

module vertex_normal_generator (
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  output logic             busy,
  input  vng_pkg::cmd_t    cmd,
  output logic             result_strobe,
  output vng_pkg::result_t result
);

  localparam int PW = vng_pkg::POSITION_WIDTH;
  localparam int DW = PW + 1;
  localparam int XW = 2 * DW;
  localparam int CW = XW + 1;

  typedef enum logic [3:0] {
    S_IDLE, S_RDA, S_RDB, S_RDC, S_DIFF, S_MUL, S_CROSS,
    S_ACCRD, S_ACCWR, S_RRD, S_RSTART, S_NORM
  } state_t;

  state_t state;
  logic [vng_pkg::INDEX_W-1:0] ia, ib, ic;
  vng_pkg::pos3_t    pa, pb;
  logic signed [DW-1:0] ax, ay, az, bx, by, bz;
  logic signed [XW-1:0] p_aybz, p_azby, p_azbx, p_axbz, p_axby, p_aybx;
  logic signed [CW-1:0] nx, ny, nz;
  logic [1:0]           corner;

  logic accept;
  logic pos_we, sum_we;
  logic [vng_pkg::INDEX_W-1:0] pos_raddr, sum_waddr, sum_raddr, corner_idx;
  vng_pkg::pos3_t pos_wdata, pos_rdata;
  vng_pkg::sum3_t sum_wdata, sum_rdata;
  logic norm_start, norm_done;
  vng_pkg::norm_res_t norm_res;

  assign busy   = (state != S_IDLE);
  assign accept = start && !busy;

  always_comb begin
    case (corner)
      2'd0:    corner_idx = ia;
      2'd1:    corner_idx = ib;
      default: corner_idx = ic;
    endcase
    pos_we    = accept && (cmd.kind == vng_pkg::KIND_LOAD);
    pos_wdata = '{x: cmd.pos_x, y: cmd.pos_y, z: cmd.pos_z};
    case (state)
      S_RDB:   pos_raddr = ib;
      S_RDC:   pos_raddr = ic;
      default: pos_raddr = ia;
    endcase
    sum_raddr = (state == S_ACCRD) ? corner_idx : ia;
    if (state == S_ACCWR) begin
      sum_we    = 1'b1;
      sum_waddr = corner_idx;
      sum_wdata = '{x: sum_rdata.x + vng_pkg::SUM_W'(nx),
                    y: sum_rdata.y + vng_pkg::SUM_W'(ny),
                    z: sum_rdata.z + vng_pkg::SUM_W'(nz)};
    end else begin
      sum_we    = pos_we;
      sum_waddr = cmd.index_a;
      sum_wdata = '0;
    end
    norm_start = (state == S_RSTART);
  end

  vng_ram #(.WIDTH($bits(vng_pkg::pos3_t)), .DEPTH(vng_pkg::VERTEX_DEPTH)) u_pos_ram (
    .clk   (clk),
    .we    (pos_we),
    .waddr (cmd.index_a),
    .wdata (pos_wdata),
    .raddr (pos_raddr),
    .rdata (pos_rdata)
  );

  vng_ram #(.WIDTH($bits(vng_pkg::sum3_t)), .DEPTH(vng_pkg::VERTEX_DEPTH)) u_sum_ram (
    .clk   (clk),
    .we    (sum_we),
    .waddr (sum_waddr),
    .wdata (sum_wdata),
    .raddr (sum_raddr),
    .rdata (sum_rdata)
  );

  vng_norm u_norm (
    .clk   (clk),
    .rst   (rst),
    .start (norm_start),
    .sums  (sum_rdata),
    .done  (norm_done),
    .res   (norm_res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_IDLE;
      result_strobe <= 1'b0;
    end else begin
      result_strobe <= 1'b0;
      case (state)
        S_IDLE: begin
          if (accept) begin
            ia <= cmd.index_a;
            ib <= cmd.index_b;
            ic <= cmd.index_c;
            if (cmd.kind == vng_pkg::KIND_TRI) begin
              state <= S_RDA;
            end else if (cmd.kind == vng_pkg::KIND_READ) begin
              state <= S_RRD;
            end
          end
        end
        S_RDA:  state <= S_RDB;
        S_RDB: begin
          pa    <= pos_rdata;
          state <= S_RDC;
        end
        S_RDC: begin
          pb    <= pos_rdata;
          state <= S_DIFF;
        end
        S_DIFF: begin
          ax <= DW'(pa.x) - DW'(pos_rdata.x);
          ay <= DW'(pa.y) - DW'(pos_rdata.y);
          az <= DW'(pa.z) - DW'(pos_rdata.z);
          bx <= DW'(pb.x) - DW'(pos_rdata.x);
          by <= DW'(pb.y) - DW'(pos_rdata.y);
          bz <= DW'(pb.z) - DW'(pos_rdata.z);
          state <= S_MUL;
        end
        S_MUL: begin
          p_aybz <= ay * bz;
          p_azby <= az * by;
          p_azbx <= az * bx;
          p_axbz <= ax * bz;
          p_axby <= ax * by;
          p_aybx <= ay * bx;
          state  <= S_CROSS;
        end
        S_CROSS: begin
          nx     <= CW'(p_aybz) - CW'(p_azby);
          ny     <= CW'(p_azbx) - CW'(p_axbz);
          nz     <= CW'(p_axby) - CW'(p_aybx);
          corner <= '0;
          state  <= S_ACCRD;
        end
        S_ACCRD: state <= S_ACCWR;
        S_ACCWR: begin
          if (corner == 2'd2) begin
            state <= S_IDLE;
          end else begin
            corner <= corner + 2'd1;
            state  <= S_ACCRD;
          end
        end
        S_RRD:    state <= S_RSTART;
        S_RSTART: state <= S_NORM;
        S_NORM: begin
          if (norm_done) begin
            result_strobe <= 1'b1;
            result <= '{vertex_index: ia, norm_x: norm_res.x, norm_y: norm_res.y,
                        norm_z: norm_res.z, degenerate: norm_res.degenerate};
            state  <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  `VNG_ASSERT_NOW(a_strobe_from_norm, result_strobe, $past(state) == S_NORM)
  `VNG_ASSERT_NEXT(a_read_starts, accept && cmd.kind == vng_pkg::KIND_READ, state == S_RRD)
  `VNG_ASSERT_NOW(a_norm_done_waited, norm_done, state == S_NORM)
  `VNG_ASSERT_NOW(a_sum_write_phase, sum_we, state == S_ACCWR || state == S_IDLE)

endmodule

@@ sv/vng_ram.sv @@
// ----------------------------------------------------------------------------
// Vertex normal generator RAM
// Simple dual-port synchronous RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
module vng_ram #(
  parameter int WIDTH = 48,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

@@ sv/vng_norm.sv @@
// ----------------------------------------------------------------------------
// Vertex normal generator normalizer
// Scales a summed normal to unit length in Q1.14: normalizing shift, sum of
// squares, bit-serial square root and bit-serial rounded division.
// ----------------------------------------------------------------------------
module vng_norm (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  input  vng_pkg::sum3_t     sums,
  output logic               done,
  output vng_pkg::norm_res_t res
);

  localparam int MW = 30;
  localparam int SW = 2 * MW + 2;
  localparam int RW = SW - 1;
  localparam int NW = MW + vng_pkg::FRAC_W + 1;
  localparam int QW = vng_pkg::FRAC_W + 1;

  typedef enum logic [2:0] {
    N_IDLE, N_SCALE, N_SQ, N_ROOT, N_DLOAD, N_DIV, N_DONE
  } nstate_t;

  nstate_t state;
  logic [2:0]                  neg;
  logic [vng_pkg::SUM_W-1:0]   mag [3];
  logic [SW-1:0]               s;
  logic [RW-1:0]               root;
  logic [RW-1:0]               rbit;
  logic [4:0]                  cnt;
  logic [1:0]                  k;
  logic [NW-1:0]               rem;
  logic [NW-1:0]               dv;
  logic [QW-1:0]               q;
  logic signed [vng_pkg::NORM_W-1:0] comp [3];
  logic                        deg;

  logic signed [vng_pkg::SUM_W-1:0] v_in [3];
  logic [vng_pkg::SUM_W-1:0]   mag_in [3];
  logic [vng_pkg::SUM_W-1:0]   maxm;
  logic [2*MW-1:0]             sq;
  logic [SW-1:0]               trial;
  logic [NW-1:0]               num;
  logic                        take;
  logic [QW-1:0]               qn;

  always_comb begin
    v_in[0] = sums.x;
    v_in[1] = sums.y;
    v_in[2] = sums.z;
    for (int i = 0; i < 3; i++) begin
      mag_in[i] = v_in[i][vng_pkg::SUM_W-1] ? (vng_pkg::SUM_W'(0) - v_in[i]) : v_in[i];
    end
    maxm = (mag[0] > mag[1]) ? mag[0] : mag[1];
    maxm = (mag[2] > maxm) ? mag[2] : maxm;
    sq    = mag[k][MW-1:0] * mag[k][MW-1:0];
    trial = {1'b0, root} + {1'b0, rbit};
    num   = NW'({mag[k][MW-1:0], {vng_pkg::FRAC_W{1'b0}}}) + NW'(root[MW:1]);
    take  = rem >= dv;
    qn    = {q[QW-2:0], take};
  end

  assign done = (state == N_DONE);
  assign res  = '{x: comp[0], y: comp[1], z: comp[2], degenerate: deg};

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= N_IDLE;
    end else begin
      case (state)
        N_IDLE: begin
          if (start) begin
            for (int i = 0; i < 3; i++) begin
              neg[i] <= v_in[i][vng_pkg::SUM_W-1];
              mag[i] <= mag_in[i];
              comp[i] <= '0;
            end
            if (sums.x == '0 && sums.y == '0 && sums.z == '0) begin
              deg   <= 1'b1;
              state <= N_DONE;
            end else begin
              deg   <= 1'b0;
              state <= N_SCALE;
            end
          end
        end
        N_SCALE: begin
          if (maxm[vng_pkg::SUM_W-1:MW] != '0) begin
            for (int i = 0; i < 3; i++) mag[i] <= mag[i] >> 1;
          end else if (!maxm[MW-1]) begin
            for (int i = 0; i < 3; i++) mag[i] <= mag[i] << 1;
          end else begin
            s     <= '0;
            k     <= '0;
            state <= N_SQ;
          end
        end
        N_SQ: begin
          s <= s + SW'(sq);
          if (k == 2'd2) begin
            root  <= '0;
            rbit  <= RW'(1) << (RW - 1);
            cnt   <= 5'(RW / 2);
            state <= N_ROOT;
          end else begin
            k <= k + 2'd1;
          end
        end
        N_ROOT: begin
          if (s >= trial) begin
            s    <= s - trial;
            root <= (root >> 1) + rbit;
          end else begin
            root <= root >> 1;
          end
          rbit <= rbit >> 2;
          if (cnt == '0) begin
            k     <= '0;
            state <= N_DLOAD;
          end else begin
            cnt <= cnt - 5'd1;
          end
        end
        N_DLOAD: begin
          rem   <= num;
          dv    <= NW'({root[MW:0], {vng_pkg::FRAC_W{1'b0}}});
          q     <= '0;
          cnt   <= 5'(vng_pkg::FRAC_W);
          state <= N_DIV;
        end
        N_DIV: begin
          if (take) begin
            rem <= rem - dv;
          end
          dv <= dv >> 1;
          q  <= qn;
          if (cnt == '0) begin
            comp[k] <= neg[k] ? (vng_pkg::NORM_W'(0) - {1'b0, qn}) : {1'b0, qn};
            if (k == 2'd2) begin
              state <= N_DONE;
            end else begin
              k     <= k + 2'd1;
              state <= N_DLOAD;
            end
          end else begin
            cnt <= cnt - 5'd1;
          end
        end
        N_DONE: begin
          state <= N_IDLE;
        end
        default: begin
          state <= N_IDLE;
        end
      endcase
    end
  end

endmodule

@@ bench/tb_vertex_normal_generator.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Vertex normal generator testbench
// Drives load, triangle, read and unused-kind words through the start/busy
// handshake, keeps its own copy of the position and normal-sum stores, and
// checks every strobed result against the predicted unit normal, in order.
// ----------------------------------------------------------------------------
module tb_vertex_normal_generator;
  import vng_pkg::*;

  localparam logic [1:0] KIND_UNUSED = 2'd3;
  localparam int WATCHDOG_LIMIT = 3000;
  localparam int RANDOM_WORDS = 400;
  localparam int QUIET_TAIL = 80;

  class normal_scoreboard;
    logic signed [POSITION_WIDTH-1:0] pos_x[VERTEX_DEPTH];
    logic signed [POSITION_WIDTH-1:0] pos_y[VERTEX_DEPTH];
    logic signed [POSITION_WIDTH-1:0] pos_z[VERTEX_DEPTH];
    logic signed [SUM_W-1:0] sum_x[VERTEX_DEPTH];
    logic signed [SUM_W-1:0] sum_y[VERTEX_DEPTH];
    logic signed [SUM_W-1:0] sum_z[VERTEX_DEPTH];
    result_t expected_normals[$];
    int errors;

    function void report(string what);
      $display("mismatch: %s", what);
      errors++;
    endfunction

    function longint unsigned root_floor(longint unsigned s);
      longint unsigned root, bit_val;
      root = 0;
      bit_val = 64'd1 << 62;
      while (bit_val > s) bit_val >>= 2;
      while (bit_val != 0) begin
        if (s >= root + bit_val) begin
          s -= root + bit_val;
          root = (root >> 1) + bit_val;
        end else begin
          root >>= 1;
        end
        bit_val >>= 2;
      end
      return root;
    endfunction

    function result_t unit_normal(logic [INDEX_W-1:0] idx);
      result_t r;
      longint signed v[3];
      longint unsigned mag[3];
      bit neg[3];
      longint unsigned maxm, s, len, q;
      r = '0;
      r.vertex_index = idx;
      v[0] = longint'(sum_x[idx]);
      v[1] = longint'(sum_y[idx]);
      v[2] = longint'(sum_z[idx]);
      maxm = 0;
      for (int k = 0; k < 3; k++) begin
        neg[k] = v[k] < 0;
        mag[k] = neg[k] ? -v[k] : v[k];
        if (mag[k] > maxm) maxm = mag[k];
      end
      if (maxm == 0) begin
        r.degenerate = 1'b1;
        return r;
      end
      while (maxm >= (64'd1 << 30)) begin
        maxm >>= 1;
        for (int k = 0; k < 3; k++) mag[k] >>= 1;
      end
      while (maxm < (64'd1 << 29)) begin
        maxm <<= 1;
        for (int k = 0; k < 3; k++) mag[k] <<= 1;
      end
      s = 0;
      for (int k = 0; k < 3; k++) s += mag[k] * mag[k];
      len = root_floor(s);
      q = (mag[0] * 16384 + len / 2) / len;
      r.norm_x = neg[0] ? -q[NORM_W-1:0] : q[NORM_W-1:0];
      q = (mag[1] * 16384 + len / 2) / len;
      r.norm_y = neg[1] ? -q[NORM_W-1:0] : q[NORM_W-1:0];
      q = (mag[2] * 16384 + len / 2) / len;
      r.norm_z = neg[2] ? -q[NORM_W-1:0] : q[NORM_W-1:0];
      return r;
    endfunction

    function void note_word(cmd_t c);
      longint signed ax, ay, az, bx, by, bz, nx, ny, nz;
      logic [INDEX_W-1:0] corner[3];
      case (c.kind)
        KIND_LOAD: begin
          pos_x[c.index_a] = c.pos_x;
          pos_y[c.index_a] = c.pos_y;
          pos_z[c.index_a] = c.pos_z;
          sum_x[c.index_a] = '0;
          sum_y[c.index_a] = '0;
          sum_z[c.index_a] = '0;
        end
        KIND_TRI: begin
          ax = longint'(pos_x[c.index_a]) - longint'(pos_x[c.index_c]);
          ay = longint'(pos_y[c.index_a]) - longint'(pos_y[c.index_c]);
          az = longint'(pos_z[c.index_a]) - longint'(pos_z[c.index_c]);
          bx = longint'(pos_x[c.index_b]) - longint'(pos_x[c.index_c]);
          by = longint'(pos_y[c.index_b]) - longint'(pos_y[c.index_c]);
          bz = longint'(pos_z[c.index_b]) - longint'(pos_z[c.index_c]);
          nx = ay * bz - az * by;
          ny = az * bx - ax * bz;
          nz = ax * by - ay * bx;
          corner[0] = c.index_a;
          corner[1] = c.index_b;
          corner[2] = c.index_c;
          for (int k = 0; k < 3; k++) begin
            sum_x[corner[k]] = sum_x[corner[k]] + nx[SUM_W-1:0];
            sum_y[corner[k]] = sum_y[corner[k]] + ny[SUM_W-1:0];
            sum_z[corner[k]] = sum_z[corner[k]] + nz[SUM_W-1:0];
          end
        end
        KIND_READ: expected_normals.push_back(unit_normal(c.index_a));
        default: ;
      endcase
    endfunction

    function void check_result(result_t got);
      result_t exp_r;
      if (expected_normals.size() == 0) begin
        report($sformatf("unexpected result for vertex %0d", got.vertex_index));
        return;
      end
      exp_r = expected_normals.pop_front();
      if (got.vertex_index !== exp_r.vertex_index)
        report($sformatf("vertex_index got %0d want %0d",
                         got.vertex_index, exp_r.vertex_index));
      if (got.norm_x !== exp_r.norm_x)
        report($sformatf("vertex %0d norm_x got %0d want %0d",
                         exp_r.vertex_index, got.norm_x, exp_r.norm_x));
      if (got.norm_y !== exp_r.norm_y)
        report($sformatf("vertex %0d norm_y got %0d want %0d",
                         exp_r.vertex_index, got.norm_y, exp_r.norm_y));
      if (got.norm_z !== exp_r.norm_z)
        report($sformatf("vertex %0d norm_z got %0d want %0d",
                         exp_r.vertex_index, got.norm_z, exp_r.norm_z));
      if (got.degenerate !== exp_r.degenerate)
        report($sformatf("vertex %0d degenerate got %0b want %0b",
                         exp_r.vertex_index, got.degenerate, exp_r.degenerate));
    endfunction
  endclass

  logic clk;
  logic rst;
  logic start;
  logic busy;
  cmd_t cmd;
  logic result_strobe;
  result_t result;

  normal_scoreboard sb;
  bit idling_on;
  bit loaded[VERTEX_DEPTH];
  int loaded_list[$];
  int quiet_cycles;

  vertex_normal_generator dut (
    .clk(clk),
    .rst(rst),
    .start(start),
    .busy(busy),
    .cmd(cmd),
    .result_strobe(result_strobe),
    .result(result)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  always @(posedge clk) begin
    if (!rst) begin
      if (start && !busy) sb.note_word(cmd);
      if (result_strobe) sb.check_result(result);
      if ((start && !busy) || result_strobe) begin
        quiet_cycles <= 0;
      end else if (quiet_cycles + 1 >= WATCHDOG_LIMIT) begin
        $display("Simulation FAILED");
        $finish;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
    end
  end

  task automatic send(cmd_t c);
    if (idling_on && $urandom_range(0, 3) == 0) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 3)) @(posedge clk);
    end
    start <= 1'b1;
    cmd <= c;
    do @(posedge clk); while (busy);
    if (c.kind == KIND_LOAD && !loaded[c.index_a]) begin
      loaded[c.index_a] = 1'b1;
      loaded_list.push_back(int'(c.index_a));
    end
  endtask

  task automatic send_load(int idx, int x, int y, int z);
    cmd_t c;
    c = '0;
    c.kind = KIND_LOAD;
    c.index_a = INDEX_W'(idx);
    c.pos_x = POSITION_WIDTH'(x);
    c.pos_y = POSITION_WIDTH'(y);
    c.pos_z = POSITION_WIDTH'(z);
    send(c);
  endtask

  task automatic send_tri(int a, int b, int cc);
    cmd_t c;
    c = '0;
    c.kind = KIND_TRI;
    c.index_a = INDEX_W'(a);
    c.index_b = INDEX_W'(b);
    c.index_c = INDEX_W'(cc);
    c.pos_x = POSITION_WIDTH'($urandom);
    send(c);
  endtask

  task automatic send_read(int idx);
    cmd_t c;
    c = '0;
    c.kind = KIND_READ;
    c.index_a = INDEX_W'(idx);
    c.index_b = INDEX_W'($urandom);
    send(c);
  endtask

  task automatic drain;
    start <= 1'b0;
    @(posedge clk);
    while (sb.expected_normals.size() != 0) @(posedge clk);
  endtask

  function automatic int pick_loaded();
    return loaded_list[$urandom_range(0, loaded_list.size() - 1)];
  endfunction

  function automatic int rand_coord();
    if ($urandom_range(0, 4) == 0) return int'($signed(16'($urandom)));
    return int'($signed(12'($urandom)));
  endfunction

  initial begin
    cmd_t junk;
    int roll;
    sb = new();
    clk = 1'b0;
    rst = 1'b1;
    start = 1'b0;
    cmd = '0;
    quiet_cycles = 0;
    idling_on = 1'b0;
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    send_load(0, 32767, -32768, 0);
    send_load(1023, -32768, 32767, 32767);
    send_load(1, 0, 0, 0);
    send_read(0);
    send_tri(0, 1, 1023);
    send_read(0);
    send_read(1);
    send_read(1023);
    send_load(682, 256, 0, 0);
    send_load(341, 512, 0, 0);
    send_tri(1, 682, 341);
    send_read(682);
    send_tri(1, 1, 682);
    send_read(1);
    junk = {KIND_UNUSED, 10'h3FF, 10'h3FF, 10'h3FF, 48'hFFFF_FFFF_FFFF};
    send(junk);
    send_load(2, -32768, -32768, -32768);
    send_tri(1023, 0, 2);
    send_tri(2, 0, 1023);
    send_read(2);
    send_read(341);
    drain();

    idling_on = 1'b1;
    for (int n = 0; n < RANDOM_WORDS; n++) begin
      if (n == RANDOM_WORDS / 2) drain();
      if (n == RANDOM_WORDS - QUIET_TAIL) idling_on = 1'b0;
      roll = $urandom_range(0, 99);
      if (roll < 18) begin
        if ($urandom_range(0, 3) == 0)
          send_load($urandom_range(0, VERTEX_DEPTH - 1), rand_coord(), rand_coord(),
                    rand_coord());
        else
          send_load($urandom_range(0, 47), rand_coord(), rand_coord(), rand_coord());
      end else if (roll < 65) begin
        send_tri(pick_loaded(), pick_loaded(), pick_loaded());
      end else if (roll < 96) begin
        send_read(pick_loaded());
      end else begin
        junk = {$urandom, $urandom, 16'($urandom)};
        junk.kind = KIND_UNUSED;
        junk.pos_x = POSITION_WIDTH'($urandom);
        send(junk);
      end
    end

    drain();
    repeat (150) @(posedge clk);
    if (sb.errors == 0 && sb.expected_normals.size() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end
endmodule
